@@ hdl/ant_pkg.sv @@
// Package for the aging neighbor table: transfer payload types, opcodes,
// sequencer states, age unit result type and reset constants. No dependencies.
`default_nettype none

package ant_pkg;

	localparam int TABLE_ENTRIES_DEF = 12;
	localparam logic [31:0] TIMEOUT_RESET = 32'd60000;
	localparam logic [47:0] BCAST_ADDR = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		OP_LEARN  = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_EXPIRE = 2'd2,
		OP_SEND   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_FIN,
		ST_EMIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [31:0]        node_id;
		logic [47:0]        station_addr;
		logic signed [7:0]  signal_level;
		logic [31:0]        now_ms;
		logic               send_ok;
	} in_t;

	typedef struct packed {
		logic               found;
		logic [47:0]        found_addr;
		logic signed [7:0]  found_level;
		logic [31:0]        ok_count;
		logic [31:0]        fail_count;
		logic               removed;
		logic [47:0]        removed_addr;
		logic [3:0]         live_count;
		logic               last;
	} out_t;

	typedef struct packed {
		logic [31:0] age;
		logic        stale;
		logic        older;
	} age_res_t;

endpackage

`default_nettype wire

@@ hdl/aging_neighbor_table.sv @@
// Aging neighbor table top level: sequencer, entry storage, output register.
// Depends on ant_pkg and ant_age_unit.
//
// channel | signals                     | direction
// in      | in_valid/in_ready, in_data  | item transfer into the table
// out     | out_valid/out_ready, out_data | result transfer, one or more per item
// cfg     | cfg_we, cfg_wdata           | peer timeout write, no wait
//
// Steps: an item scans the entries one by one (a hit ends the scan early), then
// passes ST_PICK and ST_FIN and waits for its result transfer; expire always
// scans the full table, then walks the stale marks in ST_EMIT with one output
// transfer per result. The scan steps through the single age unit and entry read
// port. Ignored learns and broadcast sends skip the scan and go straight to ST_OUT.
// Reset clears valid bits and live count and sets timeout to TIMEOUT_RESET; no clearing pass.
// A stalled result holds in the output register; in_ready stays low meanwhile.
`default_nettype none

module aging_neighbor_table import ant_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_t         in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_t             out_data,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// entry storage: valid bits reset, payload written before use
	logic [TABLE_ENTRIES-1:0] used_q;
	logic [31:0]              node_q  [TABLE_ENTRIES];
	logic [47:0]              addr_q  [TABLE_ENTRIES];
	logic signed [7:0]        level_q [TABLE_ENTRIES];
	logic [31:0]              seen_q  [TABLE_ENTRIES];
	logic [31:0]              okc_q   [TABLE_ENTRIES];
	logic [31:0]              failc_q [TABLE_ENTRIES];

	state_t                   state_q, state_d;
	in_t                      op_q;
	logic [31:0]              timeout_q;
	logic [IDX_W-1:0]         idx_q, slot_q, oldest_q;
	logic [31:0]              oldest_age_q;
	logic                     hit_q, free_q, more_q;
	logic [TABLE_ENTRIES-1:0] stale_q;
	logic [CNT_W-1:0]         stale_cnt_q, live_q;
	logic                     out_valid_q;
	out_t                     out_q;

	// current scan entry and shared age unit
	logic              cur_used, cur_hit, cur_stale, last_idx, in_skip, load_out;
	logic [CNT_W-1:0]  stale_total, live_learn;
	age_res_t          ar;
	out_t              out_d;

	ant_age_unit u_age (
		.now_ms     (op_q.now_ms),
		.seen       (seen_q[idx_q]),
		.timeout    (timeout_q),
		.oldest_age (oldest_age_q),
		.res        (ar)
	);

	assign cur_used    = used_q[idx_q];
	assign cur_stale   = cur_used & ar.stale;
	assign last_idx    = (idx_q == LAST_IDX);
	assign stale_total = stale_cnt_q + CNT_W'(cur_stale);
	assign live_learn  = live_q + CNT_W'(!hit_q && free_q);
	assign in_skip     = ((in_data.opcode == OP_LEARN) &&
			((in_data.node_id == 32'd0) || (in_data.station_addr == BCAST_ADDR))) ||
			((in_data.opcode == OP_SEND) && (in_data.station_addr == BCAST_ADDR));

	always_comb begin
		case (op_q.opcode)
			OP_LEARN:  cur_hit = cur_used & ((node_q[idx_q] == op_q.node_id) ||
					(addr_q[idx_q] == op_q.station_addr));
			OP_LOOKUP: cur_hit = cur_used & (node_q[idx_q] == op_q.node_id) & ~ar.stale;
			OP_SEND:   cur_hit = cur_used & (addr_q[idx_q] == op_q.station_addr);
			default:   cur_hit = 1'b0;
		endcase
	end

	// next state and result assembly
	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		out_d    = '0;
		out_d.live_count = 4'(live_q);
		out_d.last       = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_skip) begin
						load_out = 1'b1;
						state_d  = ST_OUT;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (op_q.opcode == OP_EXPIRE) begin
					if (last_idx) begin
						if (stale_total == '0) begin
							load_out = 1'b1;
							state_d  = ST_OUT;
						end else begin
							state_d = ST_EMIT;
						end
					end
				end else if (cur_hit || last_idx) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: state_d = ST_FIN;
			ST_FIN: begin
				load_out = 1'b1;
				state_d  = ST_OUT;
				case (op_q.opcode)
					OP_LEARN: begin
						out_d.found       = 1'b1;
						out_d.found_addr  = op_q.station_addr;
						out_d.found_level = op_q.signal_level;
						out_d.ok_count    = (!hit_q && free_q) ? 32'd0 : okc_q[idx_q];
						out_d.fail_count  = (!hit_q && free_q) ? 32'd0 : failc_q[idx_q];
						out_d.removed     = !hit_q && !free_q &&
								(addr_q[idx_q] != op_q.station_addr);
						out_d.removed_addr = out_d.removed ? addr_q[idx_q] : 48'd0;
						out_d.live_count  = 4'(live_learn);
					end
					OP_LOOKUP, OP_SEND: begin
						if (hit_q) begin
							out_d.found       = 1'b1;
							out_d.found_addr  = addr_q[idx_q];
							out_d.found_level = level_q[idx_q];
							out_d.ok_count    = okc_q[idx_q];
							out_d.fail_count  = failc_q[idx_q];
							if (op_q.opcode == OP_SEND) begin
								if (op_q.send_ok)
									out_d.ok_count = okc_q[idx_q] + 32'd1;
								else
									out_d.fail_count = failc_q[idx_q] + 32'd1;
							end
						end
					end
					default: ;
				endcase
			end
			ST_EMIT: begin
				if (stale_q[idx_q]) begin
					load_out           = 1'b1;
					state_d            = ST_OUT;
					out_d.removed      = 1'b1;
					out_d.removed_addr = addr_q[idx_q];
					out_d.last         = (stale_cnt_q == CNT_W'(1));
				end
			end
			ST_OUT: begin
				if (out_ready)
					state_d = more_q ? ST_EMIT : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			live_q       <= '0;
			timeout_q    <= TIMEOUT_RESET;
			out_valid_q  <= 1'b0;
			idx_q        <= '0;
			slot_q       <= '0;
			oldest_q     <= '0;
			oldest_age_q <= '0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			more_q       <= 1'b0;
			stale_q      <= '0;
			stale_cnt_q  <= '0;
		end else begin
			if (cfg_we)
				timeout_q <= cfg_wdata;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (state_q == ST_OUT && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					// start a fresh scan
					idx_q        <= '0;
					hit_q        <= 1'b0;
					free_q       <= 1'b0;
					oldest_q     <= '0;
					oldest_age_q <= '0;
					more_q       <= 1'b0;
					stale_q      <= '0;
					stale_cnt_q  <= '0;
				end
				ST_SCAN: begin
					if (op_q.opcode == OP_EXPIRE) begin
						stale_q[idx_q] <= cur_stale;
						stale_cnt_q    <= stale_total;
						if (last_idx) begin
							live_q <= live_q - stale_total;
							more_q <= (stale_total != '0);
							idx_q  <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						if (cur_hit) begin
							hit_q  <= 1'b1;
							slot_q <= idx_q;
						end else if (!cur_used && !free_q) begin
							free_q <= 1'b1;
							slot_q <= idx_q;
						end
						if (cur_used && ar.older) begin
							oldest_q     <= idx_q;
							oldest_age_q <= ar.age;
						end
						if (!cur_hit && !last_idx)
							idx_q <= idx_q + 1'b1;
					end
				end
				ST_PICK: begin
					// point the read port at the chosen slot
					idx_q <= (hit_q || free_q) ? slot_q : oldest_q;
				end
				ST_FIN: begin
					if (op_q.opcode == OP_LEARN) begin
						used_q[idx_q] <= 1'b1;
						live_q        <= live_learn;
					end
				end
				ST_EMIT: begin
					if (stale_q[idx_q]) begin
						used_q[idx_q]  <= 1'b0;
						stale_q[idx_q] <= 1'b0;
						stale_cnt_q    <= stale_cnt_q - 1'b1;
						more_q         <= (stale_cnt_q != CNT_W'(1));
					end
					if (!last_idx)
						idx_q <= idx_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid)
			op_q <= in_data;
		if (load_out)
			out_q <= out_d;
		if (state_q == ST_FIN) begin
			if (op_q.opcode == OP_LEARN) begin
				node_q[idx_q]  <= op_q.node_id;
				addr_q[idx_q]  <= op_q.station_addr;
				level_q[idx_q] <= op_q.signal_level;
				seen_q[idx_q]  <= op_q.now_ms;
				if (!hit_q && free_q) begin
					okc_q[idx_q]   <= 32'd0;
					failc_q[idx_q] <= 32'd0;
				end
			end else if (op_q.opcode == OP_SEND && hit_q) begin
				if (op_q.send_ok)
					okc_q[idx_q] <= okc_q[idx_q] + 32'd1;
				else
					failc_q[idx_q] <= failc_q[idx_q] + 32'd1;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	a_ready_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input ready while a result waits");
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CNT_W'(TABLE_ENTRIES))
		else $error("live count above table size");
	a_emit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (stale_cnt_q != '0))
		else $error("stale walk with nothing pending");
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready right after an item transfer");
`endif

endmodule

`default_nettype wire

@@ hdl/ant_age_unit.sv @@
// Shared age unit: one wrapping subtract and two compares per cycle.
// Depends on ant_pkg.
`default_nettype none

module ant_age_unit import ant_pkg::*; (
	input  wire logic [31:0] now_ms,
	input  wire logic [31:0] seen,
	input  wire logic [31:0] timeout,
	input  wire logic [31:0] oldest_age,
	output age_res_t         res
);

	logic [31:0] age;

	assign age = now_ms - seen;

	always_comb begin
		res.age   = age;
		res.stale = (age >= timeout);
		res.older = (age >= oldest_age);
	end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Testbench for aging_neighbor_table: runs directed and random table operations,
// predicts every result in a software copy of the table, and checks each result transfer.
// Depends on ant_pkg and the aging_neighbor_table RTL.
`timescale 1ns / 1ps

module tb_top;
	import ant_pkg::*;

	localparam int ENTRIES = 12;
	localparam int LIMIT_CYCLES = 400000;
	localparam logic [47:0] ALL_ONES = 48'hFFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	aging_neighbor_table dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// Shadow copy of the table and the timeout register.
	logic        tbl_used [ENTRIES];
	logic [31:0] tbl_node [ENTRIES];
	logic [47:0] tbl_addr [ENTRIES];
	logic [7:0]  tbl_level[ENTRIES];
	logic [31:0] tbl_seen [ENTRIES];
	logic [31:0] tbl_ok   [ENTRIES];
	logic [31:0] tbl_fail [ENTRIES];
	logic [31:0] timeout_ms;

	in_t  pending_items[$];
	out_t expected_results[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_off_left = 0;
	int cycle_count = 0;
	int error_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int removals_seen = 0;

	function automatic void put_entry(ref out_t r, input int e);
		r.found       = 1'b1;
		r.found_addr  = tbl_addr[e];
		r.found_level = tbl_level[e];
		r.ok_count    = tbl_ok[e];
		r.fail_count  = tbl_fail[e];
	endfunction

	function automatic logic [3:0] count_live();
		logic [3:0] n;
		n = 0;
		for (int i = 0; i < ENTRIES; i++) n += tbl_used[i];
		return n;
	endfunction

	// Apply one item to the shadow table and push the results it yields.
	function automatic void predict_table_op(in_t it);
		out_t res[$];
		out_t r;
		int slot, oldest;
		logic [31:0] oldest_age, age;
		logic [47:0] old_addr;
		logic replacing;
		r = '0;
		case (opcode_t'(it.opcode))
			OP_LEARN: begin
				if (it.node_id != 0 && it.station_addr != ALL_ONES) begin
					slot = -1;
					oldest = 0;
					oldest_age = 0;
					replacing = 1'b0;
					for (int i = 0; i < ENTRIES; i++) begin
						if (tbl_used[i] && (tbl_node[i] == it.node_id ||
								tbl_addr[i] == it.station_addr)) begin
							slot = i;
							break;
						end
						if (!tbl_used[i] && slot < 0) slot = i;
						if (tbl_used[i]) begin
							age = it.now_ms - tbl_seen[i];
							if (age >= oldest_age) begin
								oldest_age = age;
								oldest = i;
							end
						end
					end
					old_addr = '0;
					if (slot < 0) begin
						slot = oldest;
						old_addr = tbl_addr[slot];
						replacing = 1'b1;
					end
					tbl_used[slot]  = 1'b1;
					tbl_node[slot]  = it.node_id;
					tbl_addr[slot]  = it.station_addr;
					tbl_level[slot] = it.signal_level;
					tbl_seen[slot]  = it.now_ms;
					put_entry(r, slot);
					if (replacing && old_addr != it.station_addr) begin
						r.removed = 1'b1;
						r.removed_addr = old_addr;
					end
				end
				res.push_back(r);
			end
			OP_LOOKUP: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (tbl_used[i] && tbl_node[i] == it.node_id &&
							(it.now_ms - tbl_seen[i]) < timeout_ms) begin
						put_entry(r, i);
						break;
					end
				end
				res.push_back(r);
			end
			OP_EXPIRE: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (tbl_used[i] && (it.now_ms - tbl_seen[i]) >= timeout_ms) begin
						r = '0;
						r.removed = 1'b1;
						r.removed_addr = tbl_addr[i];
						res.push_back(r);
						tbl_used[i] = 0; tbl_node[i] = 0; tbl_addr[i] = 0;
						tbl_level[i] = 0; tbl_seen[i] = 0; tbl_ok[i] = 0; tbl_fail[i] = 0;
					end
				end
				if (res.size() == 0) begin
					r = '0;
					res.push_back(r);
				end
			end
			default: begin
				if (it.station_addr != ALL_ONES) begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (tbl_used[i] && tbl_addr[i] == it.station_addr) begin
							if (it.send_ok) tbl_ok[i] = tbl_ok[i] + 1;
							else tbl_fail[i] = tbl_fail[i] + 1;
							put_entry(r, i);
							break;
						end
					end
				end
				res.push_back(r);
			end
		endcase
		foreach (res[k]) begin
			res[k].live_count = count_live();
			res[k].last = (k == res.size() - 1);
			expected_results.push_back(res[k]);
		end
	endfunction

	// Sample handshakes at the rising edge; the driver sees them at the next fall.
	logic in_ready_q = 1'b0;
	logic in_fire;

	// Driver: advance to the next pending item at the falling edge.
	always @(negedge clk) begin
		in_fire = in_valid && in_ready_q;
		if (!in_valid || in_fire) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		if (hold_off_left > 0) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Receiver hold-off: count the long stall down one cycle at a time.
	always @(negedge clk) begin
		if (hold_off_left > 0)
			hold_off_left <= hold_off_left - 1;
	end

	always @(posedge clk) begin
		in_ready_q <= in_valid && in_ready;
		cycle_count <= cycle_count + 1;
		if (arst_n && in_valid && in_ready) begin
			predict_table_op(in_data);
			items_sent <= items_sent + 1;
		end
	end

	// Monitor: compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		out_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (out_data.removed) removals_seen <= removals_seen + 1;
			if (expected_results.size() == 0) begin
				$error("result transfer with no expectation waiting");
				error_count <= error_count + 1;
			end else begin
				exp_r = expected_results.pop_front();
				if (out_data.found !== exp_r.found)
					$error("found exp %0h got %0h", exp_r.found, out_data.found);
				if (out_data.found_addr !== exp_r.found_addr)
					$error("found_addr exp %0h got %0h", exp_r.found_addr, out_data.found_addr);
				if (out_data.found_level !== exp_r.found_level)
					$error("found_level exp %0d got %0d", exp_r.found_level,
						out_data.found_level);
				if (out_data.ok_count !== exp_r.ok_count)
					$error("ok_count exp %0h got %0h", exp_r.ok_count, out_data.ok_count);
				if (out_data.fail_count !== exp_r.fail_count)
					$error("fail_count exp %0h got %0h", exp_r.fail_count, out_data.fail_count);
				if (out_data.removed !== exp_r.removed)
					$error("removed exp %0h got %0h", exp_r.removed, out_data.removed);
				if (out_data.removed_addr !== exp_r.removed_addr)
					$error("removed_addr exp %0h got %0h", exp_r.removed_addr,
						out_data.removed_addr);
				if (out_data.live_count !== exp_r.live_count)
					$error("live_count exp %0d got %0d", exp_r.live_count, out_data.live_count);
				if (out_data.last !== exp_r.last)
					$error("last exp %0h got %0h", exp_r.last, out_data.last);
				if (out_data !== exp_r) error_count <= error_count + 1;
			end
		end
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		if (cycle_count > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Small pools of nodes and addresses so learns collide, match and evict.
	logic [31:0] node_pool[16];
	logic [47:0] addr_pool[16];
	logic [31:0] clock_ms;

	function automatic in_t make_item(opcode_t op, logic [31:0] node, logic [47:0] addr,
			logic [7:0] level, logic [31:0] now, logic ok);
		in_t it;
		it.opcode = op;
		it.node_id = node;
		it.station_addr = addr;
		it.signal_level = level;
		it.now_ms = now;
		it.send_ok = ok;
		return it;
	endfunction

	function automatic in_t random_item();
		int pick;
		logic [31:0] node;
		logic [47:0] addr;
		logic [7:0] level;
		logic ok;
		clock_ms = clock_ms + $urandom_range(4000);
		pick = $urandom_range(99);
		node = ($urandom_range(9) == 0) ? $urandom : node_pool[$urandom_range(15)];
		addr = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom}) :
			addr_pool[$urandom_range(15)];
		level = 8'($urandom);
		ok = 1'($urandom);
		if ($urandom_range(39) == 0) node = 0;
		if ($urandom_range(39) == 0) addr = ALL_ONES;
		if (pick < 45) return make_item(OP_LEARN, node, addr, level, clock_ms, ok);
		if (pick < 70) return make_item(OP_LOOKUP, node, addr, level, clock_ms, ok);
		if (pick < 80) return make_item(OP_EXPIRE, node, addr, level, clock_ms, ok);
		return make_item(OP_SEND, node, addr, level, clock_ms, ok);
	endfunction

	// Wait until every expected result is in, then let the scan drain.
	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Write the timeout while the block is idle.
	task automatic set_timeout(logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		timeout_ms = value;
	endtask

	task automatic random_phase(int count);
		repeat (count) pending_items.push_back(random_item());
		drain();
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_used[i] = 0; tbl_node[i] = 0; tbl_addr[i] = 0; tbl_level[i] = 0;
			tbl_seen[i] = 0; tbl_ok[i] = 0; tbl_fail[i] = 0;
		end
		timeout_ms = TIMEOUT_RESET;
		clock_ms = 32'hFFFF_0000;
		for (int i = 0; i < 16; i++) begin
			node_pool[i] = (i == 0) ? 32'hFFFF_FFFF : $urandom;
			addr_pool[i] = (i == 0) ? 48'hFFFF_FFFF_FFFE : (i == 1) ? 48'h0 :
				48'({$urandom, $urandom});
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: ignored learns, fill past capacity, matches, sends, expiry.
		send_idle_pct = 19;
		recv_idle_pct = 84;
		pending_items.push_back(make_item(OP_LEARN, 32'd0, 48'h1, 8'h7F, 32'd0, 1'b0));
		pending_items.push_back(make_item(OP_LEARN, 32'd5, ALL_ONES, 8'h80, 32'd0, 1'b1));
		for (int i = 0; i < 13; i++)
			pending_items.push_back(make_item(OP_LEARN, 32'd100 + i, 48'h100 + i,
				(i[0] ? 8'h80 : 8'h7F), 32'd10 + (i == 3 ? 0 : i), 1'b0));
		pending_items.push_back(make_item(OP_LEARN, 32'd101, 48'hABC, 8'h01, 32'd50, 1'b0));
		pending_items.push_back(make_item(OP_SEND, 32'd0, 48'hABC, 8'h0, 32'd50, 1'b1));
		pending_items.push_back(make_item(OP_SEND, 32'd0, 48'hABC, 8'h0, 32'd50, 1'b0));
		pending_items.push_back(make_item(OP_SEND, 32'd0, ALL_ONES, 8'h0, 32'd50, 1'b1));
		pending_items.push_back(make_item(OP_SEND, 32'd0, 48'h999, 8'h0, 32'd50, 1'b1));
		pending_items.push_back(make_item(OP_LOOKUP, 32'd101, 48'h0, 8'h0, 32'd60, 1'b0));
		pending_items.push_back(make_item(OP_LOOKUP, 32'd7777, 48'h0, 8'h0, 32'd60, 1'b0));
		pending_items.push_back(make_item(OP_EXPIRE, 32'd0, 48'h0, 8'h0, 32'd70, 1'b0));
		pending_items.push_back(make_item(OP_EXPIRE, 32'hFFFF_FFFF, ALL_ONES, 8'hFF,
			32'hFFFF_FFFF, 1'b1));
		drain();

		// Zero timeout: everything is stale, lookups all miss.
		set_timeout(32'd0);
		random_phase(30);
		set_timeout(32'hFFFF_FFFF);
		random_phase(90);
		// Hold off the receiver so the block backs up on its input.
		hold_off_left = 300;
		set_timeout(32'd1);
		random_phase(40);

		send_idle_pct = 84;
		recv_idle_pct = 19;
		set_timeout(32'd6000);
		random_phase(150);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_timeout(32'd20000);
		random_phase(140);

		$display("Covered %0d items and %0d results, %0d with an eviction or expiry.",
			items_sent, results_seen, removals_seen);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hdl/ant_pkg.sv
hdl/ant_age_unit.sv
hdl/aging_neighbor_table.sv
test/tb_top.sv
